// ===== hdl/tbd_pkg.sv =====
// Shared types and constants for the thermal backlight derating unit.
// No dependencies; imported by every module of the block.
package tbd_pkg;

    // field widths
    localparam int TEMP_W    = 18;
    localparam int DUTY_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int TICK_W    = 6;
    localparam int SCALED_W  = 2 * DUTY_W;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // bit-serial multiplier: DUTY_W x DUTY_W, one multiplier bit per cycle
    localparam int MUL_W     = DUTY_W;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    // bit-serial divide by a constant: one quotient bit per cycle
    localparam int DIV_W      = SCALED_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int RAMP_DIVISOR = 5;
    localparam int DIV_REM_W  = $clog2(RAMP_DIVISOR);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_TEMP    = 3'd0,
        REG_STOP_TEMP     = 3'd1,
        REG_DUTY_SCALE    = 3'd2,
        REG_PERSIST_TICKS = 3'd3,
        REG_FLOOR_DUTY    = 3'd4,
        REG_RAMP_TICKS    = 3'd5,
        REG_RAMP_END_TICK = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [TEMP_W-1:0]  start_temp;
        logic [TEMP_W-1:0]  stop_temp;
        logic [DUTY_W-1:0]  duty_scale;
        logic [COUNT_W-1:0] persist_ticks;
        logic [DUTY_W-1:0]  floor_duty;
        logic [TICK_W-1:0]  ramp_ticks;
        logic [TICK_W-1:0]  ramp_end_tick;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_temp:    TEMP_W'(95000),
        stop_temp:     TEMP_W'(75000),
        duty_scale:    DUTY_W'(1),
        persist_ticks: COUNT_W'(50),
        floor_duty:    DUTY_W'(27),
        ramp_ticks:    TICK_W'(4),
        ramp_end_tick: TICK_W'(5)
    };

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [DUTY_W-1:0] requested_duty;
    } t_in_word;

    typedef struct packed {
        logic              duty_write;
        logic [DUTY_W-1:0] duty_value;
        logic              derating_on;
    } t_out_word;

endpackage

// ===== hdl/thermal_backlight_derating_unit.sv =====
// Top level of the thermal backlight derating unit: tick sequencer, output register.
// Depends on tbd_pkg, tbd_cfg_regs, tbd_serial_mul and tbd_serial_div.
//
// One input word per temperature tick gives exactly one output word. A word with
// no ramp running goes straight to the finish state; a ramp hold or ramp end tick
// uses the shared 8-bit bit-serial multiplier for the scaled duty, and a ramp step
// tick uses it again for count x step after the bit-serial divide by five. Input
// stall is low only when no word is in flight, so no new word is taken before the
// last one is through the sequence; the finished word sits in an output register,
// so a new word is taken while the previous result still waits on output stall.
// Configuration goes through an APB-style port, registers at 4*index; the user must
// write only while the block is idle, which the block itself does not enforce.
module thermal_backlight_derating_unit
    import tbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,   // waiting for a tick word
        S_SCALE  = 5'b00010,   // saved duty x duty_scale
        S_STEP   = 5'b00100,   // (scaled - floor) / 5
        S_PROD   = 5'b01000,   // ramp count x step
        S_FINISH = 5'b10000    // hand result to the output register
    } t_state;

    t_cfg cfg;

    t_state             r_state, n_state;
    logic               r_go, n_go;
    // derating control state
    logic               r_der, n_der;
    logic [COUNT_W-1:0] r_on, n_on;
    logic [COUNT_W-1:0] r_off, n_off;
    logic               r_ramp, n_ramp;
    logic [COUNT_W-1:0] r_rc, n_rc;
    logic [DUTY_W-1:0]  r_saved, n_saved;
    // per-word working values
    logic [SCALED_W-1:0] r_scaled, n_scaled;
    logic                r_wr, n_wr;
    logic [DUTY_W-1:0]   r_val, n_val;
    // output register
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                in_acc;
    logic                out_free;
    logic                ramp_dir_ok;
    logic                mul_start, mul_done;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [2*MUL_W-1:0]  mul_product;
    logic                div_start, div_done;
    logic [DUTY_W-1:0]   div_quotient;
    logic [DUTY_W-1:0]   prod_lo;

    tbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // one multiplier shared between the scaled duty and the ramp offset
    assign mul_start = r_go & ((r_state == S_SCALE) | (r_state == S_PROD));
    assign mul_a     = (r_state == S_PROD) ? div_quotient : r_saved;
    assign mul_b     = (r_state == S_PROD) ? r_rc : cfg.duty_scale;

    tbd_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    assign div_start = r_go & (r_state == S_STEP);

    tbd_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_scaled - SCALED_W'(cfg.floor_duty)),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = ~r_out_valid | ~i_out_stall;
    // a ramp tick only drives a duty while one of the persistence counters runs
    assign ramp_dir_ok = (r_on != '0) | (r_off != '0);
    assign prod_lo     = mul_product[DUTY_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        n_der    = r_der;
        n_on     = r_on;
        n_off    = r_off;
        n_ramp   = r_ramp;
        n_rc     = r_rc;
        n_saved  = r_saved;
        n_scaled = r_scaled;
        n_wr     = r_wr;
        n_val    = r_val;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // hysteresis: count qualifying ticks, switch on persist + 1
                    if (!r_der) begin
                        if (i_in_word.temperature >= cfg.start_temp) begin
                            n_on = r_on + 1'b1;
                            if (r_on == cfg.persist_ticks) begin
                                n_der   = 1'b1;
                                n_off   = '0;
                                n_saved = i_in_word.requested_duty;
                                n_ramp  = 1'b1;
                            end
                        end else begin
                            n_on = '0;
                        end
                    end else begin
                        if (i_in_word.temperature <= cfg.stop_temp) begin
                            n_off = r_off + 1'b1;
                            if (r_off == cfg.persist_ticks) begin
                                n_der   = 1'b0;
                                n_on    = '0;
                                n_saved = i_in_word.requested_duty;
                                n_ramp  = 1'b1;
                            end
                        end else begin
                            n_off = '0;
                        end
                    end
                    n_wr = 1'b0;
                    if (n_ramp) begin
                        n_state = S_SCALE;
                        n_go    = 1'b1;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCALE: begin
                if (mul_done) begin
                    n_scaled = mul_product;
                    if (mul_product > SCALED_W'(cfg.floor_duty)) begin
                        n_rc = r_rc + 1'b1;
                        if (r_rc < COUNT_W'(cfg.ramp_ticks)) begin
                            // ramp step: needs the step size first
                            n_wr    = ramp_dir_ok;
                            n_state = S_STEP;
                            n_go    = 1'b1;
                        end else begin
                            if (r_rc < COUNT_W'(cfg.ramp_end_tick)) begin
                                // hold at the end point of the ramp
                                n_wr  = ramp_dir_ok;
                                n_val = (r_on != '0) ? cfg.floor_duty
                                                     : mul_product[DUTY_W-1:0];
                            end else begin
                                n_rc   = '0;
                                n_ramp = 1'b0;
                            end
                            n_state = S_FINISH;
                        end
                    end else begin
                        // scaled at or below floor: ramp stays armed, nothing driven
                        n_state = S_FINISH;
                    end
                end
            end
            S_STEP: begin
                if (div_done) begin
                    n_state = S_PROD;
                    n_go    = 1'b1;
                end
            end
            S_PROD: begin
                if (mul_done) begin
                    // down toward the floor while derating, else up from it
                    n_val   = (r_on != '0) ? (r_scaled[DUTY_W-1:0] - prod_lo)
                                           : (cfg.floor_duty + prod_lo);
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_der       <= 1'b0;
            r_on        <= '0;
            r_off       <= '0;
            r_ramp      <= 1'b0;
            r_rc        <= '0;
            r_saved     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_der   <= n_der;
            r_on    <= n_on;
            r_off   <= n_off;
            r_ramp  <= n_ramp;
            r_rc    <= n_rc;
            r_saved <= n_saved;
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working values and output word carry no reset
    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
        r_wr     <= n_wr;
        r_val    <= n_val;
        if ((r_state == S_FINISH) && out_free) begin
            r_out_word.duty_write  <= r_wr;
            r_out_word.duty_value  <= r_wr ? r_val : '0;
            r_out_word.derating_on <= r_der;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken without entering the sequence");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == S_SCALE) || (r_state == S_PROD)))
        else $error("multiplier finished outside a multiply state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_STEP))
        else $error("divider finished outside the step state");

    a_derate_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_der != $past(r_der)) |-> $past(in_acc))
        else $error("derating state changed without a tick");

    a_idle_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.duty_write) |-> (o_out_word.duty_value == '0))
        else $error("duty value driven without a duty write");
`endif

endmodule

// ===== hdl/tbd_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on tbd_pkg (t_cfg, register indexes, reset values).
module tbd_cfg_regs
    import tbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_START_TEMP:    n_cfg.start_temp    = pwdata[TEMP_W-1:0];
                REG_STOP_TEMP:     n_cfg.stop_temp     = pwdata[TEMP_W-1:0];
                REG_DUTY_SCALE:    n_cfg.duty_scale    = pwdata[DUTY_W-1:0];
                REG_PERSIST_TICKS: n_cfg.persist_ticks = pwdata[COUNT_W-1:0];
                REG_FLOOR_DUTY:    n_cfg.floor_duty    = pwdata[DUTY_W-1:0];
                REG_RAMP_TICKS:    n_cfg.ramp_ticks    = pwdata[TICK_W-1:0];
                REG_RAMP_END_TICK: n_cfg.ramp_end_tick = pwdata[TICK_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START_TEMP:    prdata = CFG_DATA_W'(r_cfg.start_temp);
            REG_STOP_TEMP:     prdata = CFG_DATA_W'(r_cfg.stop_temp);
            REG_DUTY_SCALE:    prdata = CFG_DATA_W'(r_cfg.duty_scale);
            REG_PERSIST_TICKS: prdata = CFG_DATA_W'(r_cfg.persist_ticks);
            REG_FLOOR_DUTY:    prdata = CFG_DATA_W'(r_cfg.floor_duty);
            REG_RAMP_TICKS:    prdata = CFG_DATA_W'(r_cfg.ramp_ticks);
            REG_RAMP_END_TICK: prdata = CFG_DATA_W'(r_cfg.ramp_end_tick);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hdl/tbd_serial_mul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle (shift-right form).
// Depends on tbd_pkg (MUL_W, MUL_CNT_W).
module tbd_serial_mul
    import tbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic               o_done,
    output logic [2*MUL_W-1:0] o_product
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_W-1:0]     r_a;
    logic [MUL_W-1:0]     r_hi;
    logic [MUL_W-1:0]     r_lo;
    logic [MUL_W:0]       sum;

    // partial sum of the high half; its low bit drops into the low half
    assign sum       = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[MUL_W:1];
            r_lo <= {sum[0], r_lo[MUL_W-1:1]};
        end
    end

endmodule

// ===== hdl/tbd_serial_div.sv =====
// Bit-serial divide by the ramp divisor, one quotient bit per cycle (restoring).
// Keeps the low DUTY_W quotient bits only. Depends on tbd_pkg.
module tbd_serial_div
    import tbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    output logic              o_done,
    output logic [DUTY_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DUTY_W-1:0]    r_quo;
    logic [DIV_REM_W:0]   trial;
    logic                 q_bit;
    logic [DIV_REM_W-1:0] rem_next;

    assign trial    = {r_rem, r_num[DIV_W-1]};
    assign q_bit    = (trial >= (DIV_REM_W+1)'(RAMP_DIVISOR));
    assign rem_next = q_bit ? DIV_REM_W'(trial - (DIV_REM_W+1)'(RAMP_DIVISOR))
                            : trial[DIV_REM_W-1:0];
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient shifts left, so the top bits fall away and the low byte remains
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= rem_next;
            r_quo <= {r_quo[DUTY_W-2:0], q_bit};
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for thermal_backlight_derating_unit.
// Depends on tbd_pkg and the unit's RTL; predicts every output word and checks
// it field by field while both channels idle and stall at random.
module tb_top;
    import tbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int TEMP_MAX    = (1 << TEMP_W) - 1;
    localparam int MAX_IDLE    = 10;
    // settle time; comfortably covers any word still in flight
    localparam int SETTLE      = 60;
    // ~1700 words at their slowest, plus the long hold and the config
    // phases, taken several times over
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT     = 700;  // words accepted before the long output hold
    localparam int HOLD_LEN    = 600;  // cycles of the long output hold

    // ------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    always #(CLK_PERIOD / 2) clk = ~clk;

    thermal_backlight_derating_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Testbench bookkeeping
    // ------------------------------------------------------------------
    t_in_word    tick_q[$];      // words waiting to be offered to the unit
    t_out_word   due_words[$];   // predicted output words, oldest first
    int          queued    = 0;  // words ever pushed onto tick_q
    int          words_in  = 0;  // words accepted on the input channel
    int          words_out = 0;  // words accepted on the output channel
    int          n_bad     = 0;
    int unsigned cycles    = 0;

    int unsigned src_wait  = 0;
    int unsigned snk_wait  = 0;
    int unsigned snk_next;
    bit          src_calm  = 1'b0;  // no idling on the input side this phase
    bit          snk_calm  = 1'b0;  // no stalling on the output side this phase
    bit          taken;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    // ------------------------------------------------------------------
    // Derating predictor: own copy of the registers and the tick state
    // ------------------------------------------------------------------
    t_cfg               cfg_now   = CFG_RESET;
    logic               drt_on    = 1'b0;  // derating active
    logic [COUNT_W-1:0] hot_run   = '0;    // consecutive ticks at/above start
    logic [COUNT_W-1:0] cool_run  = '0;    // consecutive ticks at/below stop
    logic               ramp_run  = 1'b0;  // ramp in progress
    logic [COUNT_W-1:0] ramp_pos  = '0;    // ramp tick counter
    logic [DUTY_W-1:0]  held_duty = '0;    // requested duty latched at a switch

    // One temperature tick: advances the derating state and returns the word
    // the unit must produce for it.
    function automatic t_out_word derate_tick(t_in_word w);
        t_out_word          res;
        logic [COUNT_W-1:0] prev;
        logic [31:0]        scaled;
        logic [31:0]        step;
        logic [31:0]        val;
        logic [31:0]        floor32;
        logic               wr;
        wr      = 1'b0;
        val     = '0;
        floor32 = 32'(cfg_now.floor_duty);

        // hysteresis with persistence; both counters wrap at 8 bits
        if (!drt_on) begin
            if (w.temperature >= cfg_now.start_temp) begin
                prev    = hot_run;
                hot_run = hot_run + 1'b1;
                if (prev == cfg_now.persist_ticks) begin
                    drt_on    = 1'b1;
                    cool_run  = '0;
                    held_duty = w.requested_duty;
                    ramp_run  = 1'b1;
                end
            end else begin
                hot_run = '0;
            end
        end else begin
            if (w.temperature <= cfg_now.stop_temp) begin
                prev     = cool_run;
                cool_run = cool_run + 1'b1;
                if (prev == cfg_now.persist_ticks) begin
                    drt_on    = 1'b0;
                    hot_run   = '0;
                    held_duty = w.requested_duty;
                    ramp_run  = 1'b1;
                end
            end else begin
                cool_run = '0;
            end
        end

        // ramp: steps, then hold writes, then one closing tick; a scaled duty
        // at or below the floor leaves the ramp flag set and does nothing
        if (ramp_run) begin
            scaled = 32'(held_duty) * 32'(cfg_now.duty_scale);
            if (scaled > floor32) begin
                step = ((scaled - floor32) / RAMP_DIVISOR) & 32'hFF;
                if (32'(ramp_pos) < 32'(cfg_now.ramp_ticks)) begin
                    ramp_pos = ramp_pos + 1'b1;
                    if (hot_run != '0) begin
                        wr  = 1'b1;
                        val = scaled - 32'(ramp_pos) * step;
                    end else if (cool_run != '0) begin
                        wr  = 1'b1;
                        val = floor32 + 32'(ramp_pos) * step;
                    end
                end else begin
                    prev     = ramp_pos;
                    ramp_pos = ramp_pos + 1'b1;
                    if (32'(prev) < 32'(cfg_now.ramp_end_tick)) begin
                        if (hot_run != '0) begin
                            wr  = 1'b1;
                            val = floor32;
                        end else if (cool_run != '0) begin
                            wr  = 1'b1;
                            val = scaled;
                        end
                    end else begin
                        ramp_pos = '0;
                        ramp_run = 1'b0;
                    end
                end
            end
        end

        res.duty_write  = wr;
        res.duty_value  = wr ? val[DUTY_W-1:0] : '0;
        res.derating_on = drt_on;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH word %0d: %s", $realtime, words_out, what);
        n_bad++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued words, random gap after each acceptance.
    // Valid is held while the unit stalls and the word never changes then.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
            src_wait <= 0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken) begin
                due_words.push_back(derate_tick(in_word));
                words_in++;
            end
            if (!in_valid || taken) begin
                if (src_wait != 0) begin
                    src_wait <= src_wait - 1;
                    in_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    in_word  <= tick_q.pop_front();
                    in_valid <= 1'b1;
                    src_wait <= src_calm ? 0 : $urandom_range(0, MAX_IDLE);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each accepted word against the oldest
    // prediction, then draws how long to stall before the next one.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            snk_wait  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_words.size() == 0) begin
                    report_mismatch($sformatf("word with nothing predicted: %p", out_word));
                end else begin
                    t_out_word want;
                    want = due_words.pop_front();
                    if (out_word.duty_write !== want.duty_write)
                        report_mismatch($sformatf("duty_write got %b want %b",
                                                  out_word.duty_write, want.duty_write));
                    if (out_word.duty_value !== want.duty_value)
                        report_mismatch($sformatf("duty_value got %0d want %0d",
                                                  out_word.duty_value, want.duty_value));
                    if (out_word.derating_on !== want.derating_on)
                        report_mismatch($sformatf("derating_on got %b want %b",
                                                  out_word.derating_on, want.derating_on));
                end
                words_out++;
                snk_next = snk_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end else begin
                snk_next = (snk_wait != 0) ? snk_wait - 1 : 0;
            end
            snk_wait  <= snk_next;
            out_stall <= (snk_next != 0) || (hold_left != 0);
        end
    end

    // Long output hold, once, while the driver keeps offering words: the
    // output register fills and the unit has to stall its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register access (APB-style, setup then access cycle)
    // ------------------------------------------------------------------
    task automatic reg_write(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // registers keep only their own width
        case (idx)
            REG_START_TEMP:    cfg_now.start_temp    = data[TEMP_W-1:0];
            REG_STOP_TEMP:     cfg_now.stop_temp     = data[TEMP_W-1:0];
            REG_DUTY_SCALE:    cfg_now.duty_scale    = data[DUTY_W-1:0];
            REG_PERSIST_TICKS: cfg_now.persist_ticks = data[COUNT_W-1:0];
            REG_FLOOR_DUTY:    cfg_now.floor_duty    = data[DUTY_W-1:0];
            REG_RAMP_TICKS:    cfg_now.ramp_ticks    = data[TICK_W-1:0];
            REG_RAMP_END_TICK: cfg_now.ramp_end_tick = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // optionally sets random bits above the register width
    function automatic logic [CFG_DATA_W-1:0] dress(logic [CFG_DATA_W-1:0] v, int w, bit junk);
        return junk ? (v | ($urandom() << w)) : v;
    endfunction

    task automatic load_cfg(t_cfg c, bit junk);
        reg_write(REG_START_TEMP,    dress(32'(c.start_temp),    TEMP_W,  junk));
        reg_write(REG_STOP_TEMP,     dress(32'(c.stop_temp),     TEMP_W,  junk));
        reg_write(REG_DUTY_SCALE,    dress(32'(c.duty_scale),    DUTY_W,  junk));
        reg_write(REG_PERSIST_TICKS, dress(32'(c.persist_ticks), COUNT_W, junk));
        reg_write(REG_FLOOR_DUTY,    dress(32'(c.floor_duty),    DUTY_W,  junk));
        reg_write(REG_RAMP_TICKS,    dress(32'(c.ramp_ticks),    TICK_W,  junk));
        reg_write(REG_RAMP_END_TICK, dress(32'(c.ramp_end_tick), TICK_W,  junk));
    endtask

    function automatic t_cfg mk_cfg(int st, int sp, int sc, int pt, int fl, int rt, int re);
        t_cfg c;
        c.start_temp    = TEMP_W'(st);
        c.stop_temp     = TEMP_W'(sp);
        c.duty_scale    = DUTY_W'(sc);
        c.persist_ticks = COUNT_W'(pt);
        c.floor_duty    = DUTY_W'(fl);
        c.ramp_ticks    = TICK_W'(rt);
        c.ramp_end_tick = TICK_W'(re);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(int temp, int duty);
        t_in_word w;
        w.temperature    = TEMP_W'(temp);
        w.requested_duty = DUTY_W'(duty);
        tick_q.push_back(w);
        queued++;
    endtask

    // duty with the extremes weighted up
    function automatic int pick_duty();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return (1 << DUTY_W) - 1;
        return $urandom_range(0, (1 << DUTY_W) - 1);
    endfunction

    function automatic int hot_temp();
        return $urandom_range(TEMP_MAX, int'(cfg_now.start_temp));
    endfunction

    function automatic int cool_temp();
        return $urandom_range(int'(cfg_now.stop_temp), 0);
    endfunction

    // Mostly well-formed hot/cool runs long enough to switch, with random
    // content; the rest are broken runs and plain noise.
    task automatic gen_ticks(int n);
        int target;
        int pick;
        int run;
        int k;
        target = queued + n;
        while (queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                run = int'(cfg_now.persist_ticks) + 1 + $urandom_range(0, 12);
                for (k = 0; k < run; k++) push_word(hot_temp(), pick_duty());
                run = int'(cfg_now.persist_ticks) + 1 + $urandom_range(0, 12);
                for (k = 0; k < run; k++) push_word(cool_temp(), pick_duty());
            end else if (pick < 85) begin
                // run cut short before it can switch
                run = $urandom_range(0, int'(cfg_now.persist_ticks));
                if ($urandom_range(0, 1) == 0) begin
                    for (k = 0; k < run; k++) push_word(hot_temp(), pick_duty());
                    push_word(cool_temp(), pick_duty());
                end else begin
                    for (k = 0; k < run; k++) push_word(cool_temp(), pick_duty());
                    push_word(hot_temp(), pick_duty());
                end
            end else begin
                push_word($urandom_range(0, TEMP_MAX), pick_duty());
            end
        end
    endtask

    // wait until every predicted word has come back, then let the unit settle
    task automatic drain();
        while (tick_q.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(t_cfg c, bit junk, int hot_lead, int n);
        int k;
        load_cfg(c, junk);
        src_calm <= ($urandom_range(0, 3) == 0);
        snk_calm <= ($urandom_range(0, 3) == 0);
        for (k = 0; k < hot_lead; k++) push_word(hot_temp(), pick_duty());
        gen_ticks(n);
        drain();
    endtask

    // Brings derating off with the on-counter at zero from any state:
    // with no persistence, hot then two cool ticks always end there.
    task automatic settle_off();
        load_cfg(mk_cfg(1000, 500, cfg_now.duty_scale, 0, cfg_now.floor_duty,
                        cfg_now.ramp_ticks, cfg_now.ramp_end_tick), 1'b0);
        push_word(TEMP_MAX, pick_duty());
        push_word(0, pick_duty());
        push_word(0, pick_duty());
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int st;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no persistence, scale 3, floor 10, 4 ramp steps, end at 6.
        load_cfg(mk_cfg(1000, 500, 3, 0, 10, 4, 6), 1'b0);
        push_word(0, 0);
        push_word(999, 255);             // just below start
        push_word(1000, 255);            // exactly at start: switch on, 765 cut to 8 bits
        repeat (5) push_word(TEMP_MAX, 128);  // remaining steps, then the hold writes
        push_word(TEMP_MAX, 0);          // closing tick of the ramp
        push_word(501, 77);              // just above stop
        push_word(500, 0);               // at stop: switch off, scaled 0 below floor
        push_word(0, 0);                 // ramp flag stuck, nothing written
        push_word(1000, 3);              // scaled 9 still below floor
        push_word(0, 4);                 // scaled 12: zero step, ramp up from floor
        push_word(0, 200);
        repeat (5) push_word(0, 0);      // steps, holds and closing tick
        push_word(TEMP_MAX, 255);
        push_word(TEMP_MAX, 1);
        drain();

        run_phase(mk_cfg(95000, 75000, 1, 2, 27, 4, 5), 1'b0, 0, 200);
        // all registers at their top but the persistence
        run_phase(mk_cfg(TEMP_MAX, TEMP_MAX, 255, 3, 255, 63, 63), 1'b0, 0, 180);
        // all registers zero: scale 0 means the ramp never writes
        run_phase(mk_cfg(0, 0, 0, 0, 0, 0, 0), 1'b0, 0, 120);

        // on-counter wrap: count to 150 under a long persistence, then
        // lower it so the count runs through 255 and back round
        settle_off();
        run_phase(mk_cfg(60000, 20000, 7, 200, 40, 10, 3), 1'b0, 150, 0);
        run_phase(mk_cfg(60000, 20000, 7, 10, 40, 10, 3), 1'b0, 120, 120);

        // persistence 255: the switch leaves both counters at zero, so the
        // ramp advances without writing
        settle_off();
        run_phase(mk_cfg(80000, 70000, 2, 255, 5, 3, 8), 1'b0, 300, 0);

        // random settings, with junk above each register's width
        repeat (2) begin
            st = $urandom_range(TEMP_MAX, 1);
            run_phase(mk_cfg(st, $urandom_range(st - 1, 0), $urandom_range(0, 255),
                             $urandom_range(0, 6), $urandom_range(0, 255),
                             $urandom_range(0, 63), $urandom_range(0, 63)),
                      1'b1, 0, 120);
        end

        // high floor: scaled duty often at or below it
        run_phase(mk_cfg(50000, 49999, 1, 1, 200, 6, 2), 1'b0, 0, 150);

        if (n_bad == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== thermal_backlight_derating_unit.f =====
hdl/tbd_pkg.sv
hdl/tbd_cfg_regs.sv
hdl/tbd_serial_mul.sv
hdl/tbd_serial_div.sv
hdl/thermal_backlight_derating_unit.sv
verif/tb_top.sv
